/* rtl/sirq_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the scanline interrupt / multiplier / split unit.
// Depends on nothing; the input stage, the core and the top level import it.
package sirq_pkg;

    localparam int VISIBLE_LINES_DEFAULT = 240;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_LINE  = 2'd2
    } action_t;

    localparam logic [15:0] ADDR_SPLIT_SCROLL = 16'h5201;
    localparam logic [15:0] ADDR_COMPARE      = 16'h5203;
    localparam logic [15:0] ADDR_STATUS       = 16'h5204;
    localparam logic [15:0] ADDR_FACTOR_A     = 16'h5205;
    localparam logic [15:0] ADDR_FACTOR_B     = 16'h5206;

    // Coarse row field of the split address wraps after row 29 and row 31
    localparam logic [4:0] ROW_LAST_VISIBLE = 5'b11101;
    localparam logic [4:0] ROW_LAST_ATTR    = 5'b11111;
    localparam logic [9:0] ROW_STEP         = 10'h020;
    localparam logic [2:0] FINE_LAST        = 3'd7;
    localparam logic [1:0] IDLE_LIMIT       = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
        logic [8:0]  line_number;
        logic        display_enabled;
    } req_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       irq_level;
        logic [9:0] split_row_address;
        logic [2:0] split_fine_row;
    } rsp_t;

endpackage

/* rtl/sirq_if.sv */
`timescale 1ns / 1ps
// Handshake channels of the unit: request, result and configuration write.
// Self-contained; used by the top level and the input stage.
interface sirq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
    logic [8:0]  line_number;
    logic        display_enabled;

    modport source (output valid, action, bus_address, write_byte, line_number,
                    display_enabled, input ready);
    modport sink (input valid, action, bus_address, write_byte, line_number,
                  display_enabled, output ready);
endinterface

interface sirq_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       irq_level;
    logic [9:0] split_row_address;
    logic [2:0] split_fine_row;

    modport source (output valid, read_byte, irq_level, split_row_address,
                    split_fine_row, input ready);
    modport sink (input valid, read_byte, irq_level, split_row_address,
                  split_fine_row, output ready);
endinterface

interface sirq_cfg_if;
    logic valid;
    logic ready;
    logic alternate_count_mode;

    modport source (output valid, alternate_count_mode, input ready);
    modport sink (input valid, alternate_count_mode, output ready);
endinterface

/* rtl/sirq_in_stage.sv */
`timescale 1ns / 1ps
// Input register of the unit: captures one request and holds it until taken.
// Depends on sirq_pkg and sirq_req_if.
module sirq_in_stage
    import sirq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sirq_req_if.sink    req,
    input  logic        take,
    output logic        valid,
    output req_t        item
);

    logic valid_reg;
    req_t item_reg;

    // Accept while empty or while the held request leaves this cycle
    assign req.ready = !valid_reg || take;
    assign valid     = valid_reg;
    assign item      = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.action          <= req.action;
            item_reg.bus_address     <= req.bus_address;
            item_reg.write_byte      <= req.write_byte;
            item_reg.line_number     <= req.line_number;
            item_reg.display_enabled <= req.display_enabled;
        end
    end

endmodule

/* rtl/sirq_core.sv */
`timescale 1ns / 1ps
// Register file, line counter, multiplier and split tracker with the result register.
// Depends on sirq_pkg.
module sirq_core
    import sirq_pkg::*;
#(
    parameter int VISIBLE_LINES = VISIBLE_LINES_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic alt_mode,
    input  logic in_valid,
    input  req_t in_item,
    output logic take,
    output logic out_valid,
    output rsp_t out_item,
    input  logic out_ready
);

    localparam logic [8:0] VIS_LIMIT = 9'(VISIBLE_LINES);

    logic [7:0] compare_reg,  compare_next;
    logic       enable_reg,   enable_next;
    logic       match_reg,    match_next;
    logic       frame_reg,    frame_next;
    logic [7:0] counter_reg,  counter_next;
    logic [1:0] idle_reg,     idle_next;
    logic       irq_reg,      irq_next;
    logic [7:0] factor_a_reg, factor_a_next;
    logic [7:0] factor_b_reg, factor_b_next;
    logic [7:0] scroll_reg,   scroll_next;
    logic [9:0] row_reg,      row_next;
    logic [2:0] fine_reg,     fine_next;
    logic [7:0] rd_byte;
    logic [15:0] product;
    logic        visible;

    logic out_valid_reg;
    rsp_t out_item_reg;

    assign take      = in_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign product = factor_a_reg * factor_b_reg;
    assign visible = in_item.display_enabled && (in_item.line_number < VIS_LIMIT);

    always_comb
    begin
        compare_next  = compare_reg;
        enable_next   = enable_reg;
        match_next    = match_reg;
        frame_next    = frame_reg;
        counter_next  = counter_reg;
        idle_next     = idle_reg;
        irq_next      = irq_reg;
        factor_a_next = factor_a_reg;
        factor_b_next = factor_b_reg;
        scroll_next   = scroll_reg;
        row_next      = row_reg;
        fine_next     = fine_reg;
        rd_byte       = 8'd0;

        case (action_t'(in_item.action))
            ACT_READ:
            begin
                rd_byte = in_item.bus_address[15:8];
                if (in_item.bus_address == ADDR_STATUS)
                begin
                    rd_byte    = {match_reg, frame_reg, 6'd0};
                    match_next = 1'b0;
                    irq_next   = 1'b0;
                end
                else if (in_item.bus_address == ADDR_FACTOR_A)
                begin
                    rd_byte = product[7:0];
                end
                else if (in_item.bus_address == ADDR_FACTOR_B)
                begin
                    rd_byte = product[15:8];
                end
            end
            ACT_WRITE:
            begin
                if (in_item.bus_address == ADDR_SPLIT_SCROLL)
                begin
                    scroll_next = in_item.write_byte;
                end
                else if (in_item.bus_address == ADDR_COMPARE)
                begin
                    compare_next = in_item.write_byte;
                    irq_next     = 1'b0;
                end
                else if (in_item.bus_address == ADDR_STATUS)
                begin
                    enable_next = in_item.write_byte[7];
                    irq_next    = 1'b0;
                end
                else if (in_item.bus_address == ADDR_FACTOR_A)
                begin
                    factor_a_next = in_item.write_byte;
                end
                else if (in_item.bus_address == ADDR_FACTOR_B)
                begin
                    factor_b_next = in_item.write_byte;
                end
            end
            ACT_LINE:
            begin
                // Alternate variant compares before the counter moves
                if (alt_mode && counter_reg == compare_reg)
                begin
                    match_next = 1'b1;
                end
                if (visible)
                begin
                    counter_next = counter_reg + 8'd1;
                    frame_next   = 1'b1;
                    idle_next    = 2'd0;
                end
                else if (alt_mode)
                begin
                    counter_next = 8'd0;
                    match_next   = 1'b0;
                    frame_next   = 1'b0;
                end
                if (!alt_mode)
                begin
                    if (counter_next == compare_reg)
                    begin
                        match_next = 1'b1;
                    end
                    if (idle_next != IDLE_LIMIT)
                    begin
                        idle_next = idle_next + 2'd1;
                    end
                    // Idle count reaching IDLE_LIMIT (two idle lines after a visible one): drop out of the frame
                    if (idle_next == IDLE_LIMIT)
                    begin
                        counter_next = 8'd0;
                        match_next   = 1'b0;
                        frame_next   = 1'b0;
                        irq_next     = 1'b0;
                    end
                end
                if (enable_reg && match_next && frame_next)
                begin
                    irq_next = 1'b1;
                end

                if (in_item.line_number == 9'd0)
                begin
                    fine_next = scroll_reg[2:0];
                    row_next  = {scroll_reg[7:3], 5'd0};
                end
                else if (in_item.display_enabled)
                begin
                    if (fine_reg == FINE_LAST)
                    begin
                        fine_next = 3'd0;
                        if (row_reg[9:5] == ROW_LAST_VISIBLE || row_reg[9:5] == ROW_LAST_ATTR)
                        begin
                            row_next = {5'd0, row_reg[4:0]};
                        end
                        else
                        begin
                            row_next = row_reg + ROW_STEP;
                        end
                    end
                    else
                    begin
                        fine_next = fine_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                rd_byte = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_reg   <= 8'd0;
            enable_reg    <= 1'b0;
            match_reg     <= 1'b0;
            frame_reg     <= 1'b0;
            counter_reg   <= 8'd0;
            idle_reg      <= 2'd0;
            irq_reg       <= 1'b0;
            factor_a_reg  <= 8'd0;
            factor_b_reg  <= 8'd0;
            scroll_reg    <= 8'd0;
            row_reg       <= 10'd0;
            fine_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                compare_reg  <= compare_next;
                enable_reg   <= enable_next;
                match_reg    <= match_next;
                frame_reg    <= frame_next;
                counter_reg  <= counter_next;
                idle_reg     <= idle_next;
                irq_reg      <= irq_next;
                factor_a_reg <= factor_a_next;
                factor_b_reg <= factor_b_next;
                scroll_reg   <= scroll_next;
                row_reg      <= row_next;
                fine_reg     <= fine_next;
            end
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_item_reg.read_byte         <= rd_byte;
            out_item_reg.irq_level         <= irq_next;
            out_item_reg.split_row_address <= row_next;
            out_item_reg.split_fine_row    <= fine_next;
        end
    end

endmodule

/* rtl/scanline_irq_multiplier_split_unit.sv */
`timescale 1ns / 1ps
// Top level: configuration register, input stage and core on handshake channels.
// Depends on sirq_pkg, sirq_if, sirq_in_stage and sirq_core.

// Each request is a bus read, a bus write or an end-of-scanline event, and
// gives exactly one result: the read data (zero for writes and events), the
// interrupt line after the request, and the split-screen row address and fine
// row. One request is accepted every clock cycle while the result channel is
// not stalled; a request passes through the input register and then the
// single pass of logic (compares, one 8x8 multiply, state update) that loads
// the result register. Both registers hold under backpressure; a stalled
// result still lets one more request enter while the input register is empty.
// The user writes the counting variant register through the always-ready
// configuration channel only while no request is in flight; not enforced here.
module scanline_irq_multiplier_split_unit
    import sirq_pkg::*;
#(
    parameter int VISIBLE_LINES = VISIBLE_LINES_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    sirq_req_if.sink req,
    sirq_rsp_if.source rsp,
    sirq_cfg_if.sink cfg
);

    logic alt_mode_reg;
    logic s1_valid;
    logic s1_take;
    req_t s1_item;
    rsp_t result;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alt_mode_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            alt_mode_reg <= cfg.alternate_count_mode;
        end
    end

    sirq_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .take  (s1_take),
        .valid (s1_valid),
        .item  (s1_item)
    );

    sirq_core #(
        .VISIBLE_LINES (VISIBLE_LINES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .alt_mode  (alt_mode_reg),
        .in_valid  (s1_valid),
        .in_item   (s1_item),
        .take      (s1_take),
        .out_valid (rsp.valid),
        .out_item  (result),
        .out_ready (rsp.ready)
    );

    assign rsp.read_byte         = result.read_byte;
    assign rsp.irq_level         = result.irq_level;
    assign rsp.split_row_address = result.split_row_address;
    assign rsp.split_fine_row    = result.split_fine_row;

endmodule
